[rtl/button_tap_and_hold_reset_sequencer_core_assert.svh]
// Assertion shorthands used by the checker file.
`ifndef BUTTON_TAP_AND_HOLD_RESET_SEQUENCER_CORE_ASSERT_SVH
`define BUTTON_TAP_AND_HOLD_RESET_SEQUENCER_CORE_ASSERT_SVH

// Clocked assertion, off while reset is asserted.
`define BTHRS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also covers the reset cycles.
`define BTHRS_ASSERT_NORST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/bthrs_pkg.sv]
package bthrs_pkg;

    localparam int CFG_W  = 16;
    localparam int NOW_W  = 32;
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;
    localparam int REG_LSB = 2;

    // register indexes
    localparam logic [1:0] REG_TAP_LIMIT    = 2'd0;
    localparam logic [1:0] REG_ARM_FULL     = 2'd1;
    localparam logic [1:0] REG_SOLID_HOLD   = 2'd2;
    localparam logic [1:0] REG_CONFIRM_DARK = 2'd3;

    localparam logic [CFG_W-1:0] TAP_LIMIT_RST    = 16'd1000;
    localparam logic [CFG_W-1:0] ARM_FULL_RST     = 16'd5000;
    localparam logic [CFG_W-1:0] SOLID_HOLD_RST   = 16'd500;
    localparam logic [CFG_W-1:0] CONFIRM_DARK_RST = 16'd2000;

    // LED override actions
    localparam logic [1:0] ACT_NONE  = 2'd0;
    localparam logic [1:0] ACT_SET   = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    // blink period: 600 - ceil(520 * d / span)
    localparam int PER_W      = 10;
    localparam int PERIOD_MAX = 600;
    localparam int DROP_HI_SH = 9;   // 520 = 512 + 8
    localparam int DROP_LO_SH = 3;
    localparam int DIV_STEPS  = 10;  // quotient never exceeds 520
    localparam int NUM_W      = 26;

    // confirm flashes
    localparam int FLASH_HALF   = 100;
    localparam int FLASH_PERIOD = 200;
    localparam int FLASH_COUNT  = 5;
    localparam int FLASH_TOTAL  = FLASH_PERIOD * FLASH_COUNT;
    localparam int FT_W         = $clog2(FLASH_TOTAL);

    typedef struct packed {
        logic [CFG_W-1:0] tap_limit_ms;
        logic [CFG_W-1:0] arm_full_ms;
        logic [CFG_W-1:0] solid_hold_ms;
        logic [CFG_W-1:0] confirm_dark_ms;
    } t_cfg;

    typedef struct packed {
        logic             start;
        logic [CFG_W-1:0] d;
        logic [CFG_W-1:0] span;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [PER_W-1:0] q;
    } t_div_rsp;

endpackage

[rtl/bthrs_if.sv]
interface bthrs_in_if;
    logic                       valid;
    logic                       ready;
    logic [bthrs_pkg::NOW_W-1:0] now_ms;
    logic                       pressed;

    modport source (output valid, output now_ms, output pressed, input ready);
    modport sink (input valid, input now_ms, input pressed, output ready);
endinterface

interface bthrs_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] led_action;
    logic       led_on;
    logic       tap_event;
    logic       reset_event;

    modport source (output valid, output led_action, output led_on, output tap_event,
                    output reset_event, input ready);
    modport sink (input valid, input led_action, input led_on, input tap_event,
                  input reset_event, output ready);
endinterface

[rtl/bthrs_cfg.sv]
module bthrs_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic [bthrs_pkg::APB_AW-1:0]  i_paddr,
    input  logic [bthrs_pkg::APB_DW-1:0]  i_pwdata,
    output logic [bthrs_pkg::APB_DW-1:0]  o_prdata,
    output logic                          o_pready,
    output bthrs_pkg::t_cfg               o_cfg
);
    import bthrs_pkg::*;

    t_cfg       r_cfg;
    logic [1:0] reg_idx;
    logic       wr_en;

    assign reg_idx  = i_paddr[APB_AW-1:REG_LSB];
    assign wr_en    = i_psel & i_penable & i_pwrite;
    assign o_pready = 1'b1;
    assign o_cfg    = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tap_limit_ms    <= TAP_LIMIT_RST;
            r_cfg.arm_full_ms     <= ARM_FULL_RST;
            r_cfg.solid_hold_ms   <= SOLID_HOLD_RST;
            r_cfg.confirm_dark_ms <= CONFIRM_DARK_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_TAP_LIMIT:    r_cfg.tap_limit_ms    <= i_pwdata[CFG_W-1:0];
                REG_ARM_FULL:     r_cfg.arm_full_ms     <= i_pwdata[CFG_W-1:0];
                REG_SOLID_HOLD:   r_cfg.solid_hold_ms   <= i_pwdata[CFG_W-1:0];
                REG_CONFIRM_DARK: r_cfg.confirm_dark_ms <= i_pwdata[CFG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_TAP_LIMIT:    o_prdata = APB_DW'(r_cfg.tap_limit_ms);
            REG_ARM_FULL:     o_prdata = APB_DW'(r_cfg.arm_full_ms);
            REG_SOLID_HOLD:   o_prdata = APB_DW'(r_cfg.solid_hold_ms);
            REG_CONFIRM_DARK: o_prdata = APB_DW'(r_cfg.confirm_dark_ms);
            default:          o_prdata = '0;
        endcase
    end

endmodule

[rtl/bthrs_div.sv]
module bthrs_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bthrs_pkg::t_div_req i_req,
    output bthrs_pkg::t_div_rsp o_rsp
);
    import bthrs_pkg::*;

    localparam int CNT_W = $clog2(DIV_STEPS);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_rem;
    logic [NUM_W-1:0] r_div;
    logic [PER_W-1:0] r_q;
    logic [NUM_W-1:0] num;
    logic [NUM_W:0]   trial;
    logic             take;

    // ceil(520*d/span) as floor((520*d + span - 1) / span)
    assign num = (NUM_W'(i_req.d) << DROP_HI_SH) + (NUM_W'(i_req.d) << DROP_LO_SH)
               + NUM_W'(i_req.span) - NUM_W'(1);

    assign trial = {1'b0, r_rem} - {1'b0, r_div};
    assign take  = ~trial[NUM_W];

    assign o_rsp.done = r_done;
    assign o_rsp.q    = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_STEPS - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - CNT_W'(1);
                end
            end
        end
    end

    // restoring division, one quotient bit per cycle, MSB first
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= num;
            r_div <= NUM_W'(i_req.span) << (DIV_STEPS - 1);
            r_q   <= '0;
        end else if (r_busy) begin
            if (take) begin
                r_rem <= trial[NUM_W-1:0];
            end
            r_div <= r_div >> 1;
            r_q   <= {r_q[PER_W-2:0], take};
        end
    end

endmodule

[rtl/button_tap_and_hold_reset_sequencer_core.sv]
// Button tap-and-hold reset sequencer.
// Input channel i_in: one transfer per millisecond tick carrying now_ms (wrapping
// time) and the button level. Output channel o_out: exactly one result per tick
// (LED override action and level, tap event, reset event). Registers sit on an
// APB port: tap limit at 0x0, arm full at 0x4, solid hold at 0x8, confirm dark
// at 0xC; write them only while no tick is in flight.
// Path of a tick: S_ELAPSE, S_DECIDE, then S_OUT loads the output register;
// the confirm flash part adds S_FLASH, and an arming tick that keeps the blink
// going adds S_BLINK and S_BCMP. Arming ticks past the tap limit and below the
// full hold also run the blink period divider (start, 10 quotient steps, done).
// A new tick is taken only once the previous one has reached the output
// register.
// Reset (synchronous, active low) returns to idle with the start times zero and the
// registers at their defaults, output empty.
// If the receiver stalls, the result is held in the output register; one more
// tick can be taken and worked, then the block waits until the output drains.
module button_tap_and_hold_reset_sequencer_core #(
    parameter int TIME_BITS = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    bthrs_in_if.sink                     i_in,
    bthrs_out_if.source                  o_out,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bthrs_pkg::APB_AW-1:0] paddr,
    input  logic [bthrs_pkg::APB_DW-1:0] pwdata,
    output logic [bthrs_pkg::APB_DW-1:0] prdata,
    output logic                         pready
);
    import bthrs_pkg::*;

    localparam int TW = TIME_BITS;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_PRESSING  = 3'd1,
        PH_ARMING    = 3'd2,
        PH_COMMITTED = 3'd3,
        PH_CONFIRM   = 3'd4
    } t_phase;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ELAPSE,
        S_DECIDE,
        S_DIV,
        S_BLINK,
        S_BCMP,
        S_FLASH,
        S_OUT
    } t_state;

    function automatic logic flash_level(input logic [FT_W-1:0] ft);
        logic lvl;
        lvl = 1'b1;
        for (int k = 1; k < 2 * FLASH_COUNT; k++) begin
            if (ft >= FT_W'(k * FLASH_HALF)) begin
                lvl = ~lvl;
            end
        end
        return lvl;
    endfunction

    t_cfg     cfg;
    t_div_req div_req;
    t_div_rsp div_rsp;

    t_state           r_state, n_state;
    t_phase           r_phase, n_phase;
    logic [TW-1:0]    r_press_start, n_press_start;
    logic [TW-1:0]    r_blink_start, n_blink_start;
    logic [TW-1:0]    r_phase_start, n_phase_start;
    logic             r_blink_level, n_blink_level;
    logic [TW-1:0]    r_now, n_now;
    logic             r_pressed, n_pressed;
    logic [TW-1:0]    r_el, n_el;
    logic [PER_W-1:0] r_period, n_period;
    logic [1:0]       r_act, n_act;
    logic             r_lvl, n_lvl;
    logic             r_tap, n_tap;
    logic             r_rst, n_rst;
    logic             r_out_valid, n_out_valid;
    logic [1:0]       r_out_act, n_out_act;
    logic             r_out_lvl, n_out_lvl;
    logic             r_out_tap, n_out_tap;
    logic             r_out_rst, n_out_rst;

    logic [TW-1:0] sub_a, sub_b, sub_y, cmp_b;
    logic [TW:0]   sub_full;
    logic          sub_borrow, cmp_ge;
    logic          in_fire;

    bthrs_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready),
        .o_cfg     (cfg)
    );

    bthrs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign i_in.ready        = (r_state == S_IDLE);
    assign in_fire           = i_in.valid & i_in.ready;
    assign o_out.valid       = r_out_valid;
    assign o_out.led_action  = r_out_act;
    assign o_out.led_on      = r_out_lvl;
    assign o_out.tap_event   = r_out_tap;
    assign o_out.reset_event = r_out_rst;

    // shared subtractor: elapsed times, excess over thresholds
    always_comb begin
        case (r_state)
            S_ELAPSE: begin
                sub_a = r_now;
                sub_b = (r_phase == PH_PRESSING || r_phase == PH_ARMING) ? r_press_start
                                                                          : r_phase_start;
            end
            S_DECIDE: begin
                sub_a = r_el;
                sub_b = (r_phase == PH_CONFIRM) ? TW'(cfg.confirm_dark_ms)
                                                : TW'(cfg.tap_limit_ms);
            end
            S_BLINK: begin
                sub_a = r_now;
                sub_b = r_blink_start;
            end
            default: begin
                sub_a = r_now;
                sub_b = r_blink_start;
            end
        endcase
    end

    assign sub_full   = {1'b0, sub_a} - {1'b0, sub_b};
    assign sub_y      = sub_full[TW-1:0];
    assign sub_borrow = sub_full[TW];

    // shared comparator: r_el against the threshold of the current step
    always_comb begin
        case (r_state)
            S_DECIDE: begin
                case (r_phase)
                    PH_PRESSING:  cmp_b = TW'(cfg.tap_limit_ms);
                    PH_ARMING:    cmp_b = TW'(cfg.arm_full_ms);
                    PH_COMMITTED: cmp_b = TW'(cfg.solid_hold_ms);
                    PH_CONFIRM:   cmp_b = TW'(cfg.confirm_dark_ms);
                    default:      cmp_b = TW'(cfg.tap_limit_ms);
                endcase
            end
            S_BCMP:  cmp_b = TW'(r_period);
            S_FLASH: cmp_b = TW'(FLASH_TOTAL);
            default: cmp_b = TW'(FLASH_TOTAL);
        endcase
    end

    assign cmp_ge = (r_el >= cmp_b);

    always_comb begin
        n_state       = r_state;
        n_phase       = r_phase;
        n_press_start = r_press_start;
        n_blink_start = r_blink_start;
        n_phase_start = r_phase_start;
        n_blink_level = r_blink_level;
        n_now         = r_now;
        n_pressed     = r_pressed;
        n_el          = r_el;
        n_period      = r_period;
        n_act         = r_act;
        n_lvl         = r_lvl;
        n_tap         = r_tap;
        n_rst         = r_rst;
        n_out_valid   = r_out_valid & ~o_out.ready;
        n_out_act     = r_out_act;
        n_out_lvl     = r_out_lvl;
        n_out_tap     = r_out_tap;
        n_out_rst     = r_out_rst;
        div_req.start = 1'b0;
        div_req.d     = sub_y[CFG_W-1:0];
        div_req.span  = cfg.arm_full_ms - cfg.tap_limit_ms;

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_now     = TW'(i_in.now_ms);
                    n_pressed = i_in.pressed;
                    n_act     = ACT_NONE;
                    n_lvl     = 1'b0;
                    n_tap     = 1'b0;
                    n_rst     = 1'b0;
                    n_state   = S_ELAPSE;
                end
            end
            S_ELAPSE: begin
                n_el    = sub_y;
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                n_state = S_OUT;
                case (r_phase)
                    PH_PRESSING: begin
                        if (!r_pressed) begin
                            n_tap   = ~cmp_ge;
                            n_phase = PH_IDLE;
                        end else if (cmp_ge) begin
                            n_phase       = PH_ARMING;
                            n_blink_start = r_now;
                            n_blink_level = 1'b0;
                        end
                    end
                    PH_ARMING: begin
                        if (!r_pressed) begin
                            n_act   = ACT_CLEAR;
                            n_phase = PH_IDLE;
                        end else if (cmp_ge) begin
                            n_phase       = PH_COMMITTED;
                            n_phase_start = r_now;
                            n_act         = ACT_SET;
                            n_lvl         = 1'b1;
                        end else if (!sub_borrow && sub_y != '0) begin
                            // hold past the tap limit: period needs the divider
                            div_req.start = 1'b1;
                            n_state       = S_DIV;
                        end else begin
                            n_period = PER_W'(PERIOD_MAX);
                            n_state  = S_BLINK;
                        end
                    end
                    PH_COMMITTED: begin
                        if (cmp_ge) begin
                            n_phase       = PH_CONFIRM;
                            n_phase_start = r_now;
                            n_act         = ACT_SET;
                            n_lvl         = 1'b0;
                        end
                    end
                    PH_CONFIRM: begin
                        n_act = ACT_SET;
                        n_lvl = 1'b0;
                        if (cmp_ge) begin
                            n_el    = sub_y;
                            n_state = S_FLASH;
                        end
                    end
                    default: begin
                        n_phase = PH_IDLE;
                        if (r_pressed) begin
                            n_phase       = PH_PRESSING;
                            n_press_start = r_now;
                        end
                    end
                endcase
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    n_period = PER_W'(PERIOD_MAX) - div_rsp.q;
                    n_state  = S_BLINK;
                end
            end
            S_BLINK: begin
                n_el    = sub_y;
                n_state = S_BCMP;
            end
            S_BCMP: begin
                n_act = ACT_SET;
                n_lvl = r_blink_level;
                if (cmp_ge) begin
                    n_blink_level = ~r_blink_level;
                    n_blink_start = r_now;
                    n_lvl         = ~r_blink_level;
                end
                n_state = S_OUT;
            end
            S_FLASH: begin
                if (cmp_ge) begin
                    n_act   = ACT_CLEAR;
                    n_lvl   = 1'b0;
                    n_phase = PH_IDLE;
                    n_rst   = 1'b1;
                end else begin
                    n_lvl = flash_level(r_el[FT_W-1:0]);
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_act   = r_act;
                    n_out_lvl   = (r_act == ACT_SET) ? r_lvl : 1'b0;
                    n_out_tap   = r_tap;
                    n_out_rst   = r_rst;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_phase       <= PH_IDLE;
            r_press_start <= '0;
            r_blink_start <= '0;
            r_phase_start <= '0;
            r_blink_level <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_phase       <= n_phase;
            r_press_start <= n_press_start;
            r_blink_start <= n_blink_start;
            r_phase_start <= n_phase_start;
            r_blink_level <= n_blink_level;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_now     <= n_now;
        r_pressed <= n_pressed;
        r_el      <= n_el;
        r_period  <= n_period;
        r_act     <= n_act;
        r_lvl     <= n_lvl;
        r_tap     <= n_tap;
        r_rst     <= n_rst;
        r_out_act <= n_out_act;
        r_out_lvl <= n_out_lvl;
        r_out_tap <= n_out_tap;
        r_out_rst <= n_out_rst;
    end

endmodule

[rtl/bthrs_chk.sv]
`include "button_tap_and_hold_reset_sequencer_core_assert.svh"

module bthrs_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [1:0] i_led_action,
    input logic       i_led_on,
    input logic       i_tap_event,
    input logic       i_reset_event
);
    import bthrs_pkg::*;

    `BTHRS_ASSERT_NORST(a_rst_empties, i_clk, !i_rst_n |=> !i_out_valid, "result valid after reset")

    `BTHRS_ASSERT(a_stall_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_led_action) && $stable(i_led_on) && $stable(i_tap_event) && $stable(i_reset_event), "result changed while stalled")

    `BTHRS_ASSERT(a_act_code, i_clk, i_rst_n, i_out_valid |-> i_led_action == ACT_NONE || i_led_action == ACT_SET || i_led_action == ACT_CLEAR, "undefined led action")

    `BTHRS_ASSERT(a_level_only_set, i_clk, i_rst_n, i_out_valid && i_led_action != ACT_SET |-> !i_led_on, "led level without set action")

    `BTHRS_ASSERT(a_reset_clears, i_clk, i_rst_n, i_out_valid && i_reset_event |-> i_led_action == ACT_CLEAR && !i_tap_event, "reset event without clear")

endmodule

bind button_tap_and_hold_reset_sequencer_core bthrs_chk u_bthrs_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_led_action  (o_out.led_action),
    .i_led_on      (o_out.led_on),
    .i_tap_event   (o_out.tap_event),
    .i_reset_event (o_out.reset_event)
);
